// ----- sv/decibel_spread_matcher_top_defines.svh -----
// assertion macros shared by the level remapper
`ifndef DECIBEL_SPREAD_MATCHER_TOP_DEFINES_SVH
`define DECIBEL_SPREAD_MATCHER_TOP_DEFINES_SVH

// same-cycle implication
`define DSM_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("level remapper check failed");

// next-cycle implication
`define DSM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("level remapper check failed");

`endif

// ----- sv/dsm_pkg.sv -----
package dsm_pkg;

	localparam int SAMPLE_BITS_DEF    = 24;
	localparam int LOG_TABLE_BITS_DEF = 8;

	localparam int TGT_W   = 14;
	localparam int DB_W    = 16;
	localparam int FRAC_W  = 16;
	localparam int ATT2_W  = 21;
	localparam int IATT_W  = 16;
	localparam int D_W     = 18;
	localparam int SPR_W   = 17;
	localparam int N_W     = 30;
	localparam int Q_W     = 29;
	localparam int DIV_W   = 17;
	localparam int REM_W   = 18;
	localparam int DELTA_W = 30;
	localparam int NEWDB_W = 31;
	localparam int B_W     = 17;
	localparam int A_W     = 23;
	localparam int IP_W    = 7;
	localparam int P_W     = 31;

	localparam logic [18:0] DB_PER_LOG2_Q16 = 19'd394566;
	localparam logic [21:0] LOG2_PER_DB_Q24 = 22'd2786635;
	localparam logic [SPR_W-1:0] SPREAD_MIN = 17'd26;
	localparam logic signed [DB_W-1:0] FLOOR_DB = -16'sd23040;
	localparam logic signed [DB_W-1:0] PEAK_RESET = -16'sd24576;
	localparam logic [IP_W-1:0] EXP_MAX_SHIFT = 7'd32;
	localparam int DB_DIV_SHIFT = 11;

	localparam logic [P_W-1:0] EXP_STEP_Q30 [13] = '{
		31'd1073741824, 31'd759250125, 31'd902905651, 31'd984625594, 31'd1028218693,
		31'd1050733755, 31'd1062175491, 31'd1067942999, 31'd1070838486, 31'd1072289173,
		31'd1073015252, 31'd1073378477, 31'd1073560166
	};

	typedef enum logic [1:0] {
		CFG_TARGET = 2'd0,
		CFG_MAX    = 2'd1,
		CFG_MIN    = 2'd2,
		CFG_NOTE   = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic valid;
		logic zero;
	} flags_t;

	// log2 fraction of 1+idx/2^lbits in Q16, by repeated squaring
	function automatic logic [FRAC_W-1:0] log_frac_q16(input int unsigned idx,
		input int unsigned lbits);
		logic [63:0] x;
		logic [FRAC_W-1:0] r;
		x = (64'(1 << lbits) + 64'(idx)) << (30 - lbits);
		r = '0;
		for (int k = 1; k <= FRAC_W; k++) begin
			x = (x * x) >> 30;
			if (x >= (64'd1 << 31)) begin
				x = x >> 1;
				r[FRAC_W-k] = 1'b1;
			end
		end
		return r;
	endfunction

endpackage

// ----- sv/decibel_spread_matcher_top.sv -----
// throughput: one sample per cycle while the skid register is empty; depth set by the
// 29-stage quotient pipeline and one exp-table multiply stage per table bit
// under output back-pressure one result is held in a skid register, then all stages stall
// reset: asynchronous, clears stage valid bits and restores register defaults
`include "decibel_spread_matcher_top_defines.svh"

module decibel_spread_matcher_top #(
	parameter int SAMPLE_BITS    = dsm_pkg::SAMPLE_BITS_DEF,
	parameter int LOG_TABLE_BITS = dsm_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [dsm_pkg::DB_W-1:0] cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SAMPLE_BITS-1:0]  sample_in,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SAMPLE_BITS-1:0]  sample_out,
	output logic                    clipped
);

	localparam int SB = SAMPLE_BITS;
	localparam logic [SB-1:0] SAT_POS = (SB'(1) << (SB - 1)) - SB'(1);
	localparam logic [SB-1:0] SAT_NEG = (SB'(1) << (SB - 1)) + SB'(1);

	logic signed [dsm_pkg::TGT_W-1:0]    target_q;
	logic signed [dsm_pkg::DB_W-1:0]     max_q, min_q;
	logic                                note_q;
	logic                                pass;
	logic                                en;

	dsm_pkg::flags_t                     log_flags, div_flags;
	logic [SB-1:0]                       log_raw, div_raw;
	logic [dsm_pkg::IATT_W-1:0]          in_att;
	logic signed [dsm_pkg::DELTA_W-1:0]  delta;
	logic                                pv, pclip;
	logic [SB-1:0]                       psample;

	logic                                skid_v_q;
	logic [SB-1:0]                       skid_sample_q;
	logic                                skid_clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			max_q    <= dsm_pkg::PEAK_RESET;
			min_q    <= dsm_pkg::PEAK_RESET;
			note_q   <= 1'b0;
		end else if (cfg_we) begin
			case (dsm_pkg::cfg_idx_t'(cfg_index))
				dsm_pkg::CFG_TARGET: target_q <= cfg_data[dsm_pkg::TGT_W-1:0];
				dsm_pkg::CFG_MAX:    max_q    <= cfg_data;
				dsm_pkg::CFG_MIN:    min_q    <= cfg_data;
				dsm_pkg::CFG_NOTE:   note_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign pass     = !note_q || (max_q <= dsm_pkg::FLOOR_DB);
	assign en       = !skid_v_q;
	assign in_ready = en;

	dsm_log #(.SB(SB), .L(LOG_TABLE_BITS)) u_log (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.valid  (in_valid && in_ready),
		.sample (sample_in),
		.flags  (log_flags),
		.raw    (log_raw),
		.in_att (in_att)
	);

	dsm_div #(.SB(SB)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.flags_in (log_flags),
		.raw_in   (log_raw),
		.in_att   (in_att),
		.max_db   (max_q),
		.min_db   (min_q),
		.flags    (div_flags),
		.raw      (div_raw),
		.delta    (delta)
	);

	dsm_exp #(.SB(SB), .L(LOG_TABLE_BITS)) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.flags_in  (div_flags),
		.raw_in    (div_raw),
		.delta     (delta),
		.target_db (target_q),
		.pass      (pass),
		.valid     (pv),
		.sample    (psample),
		.clip      (pclip)
	);

	// skid register takes the result when the output stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (pv && !out_ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && pv && !out_ready) begin
			skid_sample_q <= psample;
			skid_clip_q   <= pclip;
		end
	end

	assign out_valid  = skid_v_q || pv;
	assign sample_out = skid_v_q ? skid_sample_q : psample;
	assign clipped    = skid_v_q ? skid_clip_q : pclip;

	`DSM_ASSERT_NOW(a_clip_not_pass, out_valid && clipped, !pass)
	`DSM_ASSERT_NOW(a_clip_value, out_valid && clipped, (sample_out == SAT_POS) || (sample_out == SAT_NEG))
	`DSM_ASSERT_NEXT(a_skid_fill, pv && !out_ready && !skid_v_q, skid_v_q && out_valid)

endmodule

// ----- sv/dsm_log.sv -----
module dsm_log #(
	parameter int SB = dsm_pkg::SAMPLE_BITS_DEF,
	parameter int L  = dsm_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        valid,
	input  logic [SB-1:0]               sample,
	output dsm_pkg::flags_t             flags,
	output logic [SB-1:0]               raw,
	output logic [dsm_pkg::IATT_W-1:0]  in_att
);

	localparam int EW = $clog2(SB);

	logic [dsm_pkg::FRAC_W-1:0] log_tab [2**L];

	for (genvar gi = 0; gi < 2**L; gi++) begin : g_tab
		assign log_tab[gi] = dsm_pkg::log_frac_q16(gi, L);
	end

	logic                         v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [SB-1:0]                raw_s1, raw_s2, raw_s3, raw_s4, raw_s5;
	logic                         zero_s2, zero_s3, zero_s4, zero_s5;
	logic [SB-1:0]                mag_s1, mag_s2;
	logic [EW-1:0]                msb_s2, lz_s3;
	logic [L-1:0]                 idx_s3;
	logic [dsm_pkg::ATT2_W-1:0]   att2_s4;
	logic [dsm_pkg::IATT_W-1:0]   in_att_s5;

	logic [EW-1:0]                msb_c, lz_c;
	logic [SB-1:0]                norm_c;
	logic [39:0]                  prod_c;

	always_comb begin
		msb_c = '0;
		for (int i = 0; i < SB; i++) begin
			if (mag_s1[i]) begin
				msb_c = EW'(i);
			end
		end
	end

	assign lz_c   = EW'(SB - 1) - msb_s2;
	assign norm_c = mag_s2 << lz_c;
	assign prod_c = 40'(att2_s4) * 40'(dsm_pkg::DB_PER_LOG2_Q16) + (40'd1 << 23);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1    <= sample;
			mag_s1    <= sample[SB-1] ? SB'(-sample) : sample;
			raw_s2    <= raw_s1;
			mag_s2    <= mag_s1;
			msb_s2    <= msb_c;
			zero_s2   <= (mag_s1 == '0);
			raw_s3    <= raw_s2;
			zero_s3   <= zero_s2;
			lz_s3     <= lz_c;
			idx_s3    <= norm_c[SB-2 -: L];
			raw_s4    <= raw_s3;
			zero_s4   <= zero_s3;
			att2_s4   <= (dsm_pkg::ATT2_W'(lz_s3) << dsm_pkg::FRAC_W)
				- dsm_pkg::ATT2_W'(log_tab[idx_s3]);
			raw_s5    <= raw_s4;
			zero_s5   <= zero_s4;
			in_att_s5 <= prod_c[39:24];
		end
	end

	assign flags  = '{valid: v_s5, zero: zero_s5};
	assign raw    = raw_s5;
	assign in_att = in_att_s5;

endmodule

// ----- sv/dsm_div.sv -----
module dsm_div #(
	parameter int SB = dsm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  dsm_pkg::flags_t                     flags_in,
	input  logic [SB-1:0]                       raw_in,
	input  logic [dsm_pkg::IATT_W-1:0]          in_att,
	input  logic signed [dsm_pkg::DB_W-1:0]     max_db,
	input  logic signed [dsm_pkg::DB_W-1:0]     min_db,
	output dsm_pkg::flags_t                     flags,
	output logic [SB-1:0]                       raw,
	output logic signed [dsm_pkg::DELTA_W-1:0]  delta
);

	localparam int QW = dsm_pkg::Q_W;

	dsm_pkg::flags_t                     f_s1, f_s2, f_s4;
	logic [SB-1:0]                       raw_s1, raw_s2, raw_s4;
	logic signed [dsm_pkg::D_W-1:0]      d_s1, d_s2;
	logic [dsm_pkg::SPR_W-1:0]           spr_s1;
	logic signed [dsm_pkg::N_W-1:0]      n_s2;
	logic [dsm_pkg::DIV_W-1:0]           dv_s2;
	logic                                use_s2;
	logic signed [dsm_pkg::DELTA_W-1:0]  delta_s4;

	dsm_pkg::flags_t                     f_s   [QW+1];
	logic [SB-1:0]                       raw_s [QW+1];
	logic signed [dsm_pkg::D_W-1:0]      d_s   [QW+1];
	logic                                use_s [QW+1];
	logic                                neg_s [QW+1];
	logic [dsm_pkg::DIV_W-1:0]           dv_s  [QW+1];
	logic [dsm_pkg::REM_W-1:0]           rem_s [QW+1];
	logic [QW-1:0]                       nq_s  [QW+1];

	logic [dsm_pkg::N_W-1:0]             n_u;
	logic [dsm_pkg::N_W-1:0]             numer_c;

	assign n_u     = n_s2;
	assign numer_c = n_u[dsm_pkg::N_W-1] ? (~n_u + dsm_pkg::N_W'(dv_s2)) : n_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_s1   <= '0;
			f_s2   <= '0;
			f_s[0] <= '0;
		end else if (en) begin
			f_s1   <= flags_in;
			f_s2   <= f_s1;
			f_s[0] <= f_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1    <= raw_in;
			d_s1      <= dsm_pkg::D_W'(max_db) + dsm_pkg::D_W'(in_att);
			spr_s1    <= dsm_pkg::SPR_W'(max_db) - dsm_pkg::SPR_W'(min_db);
			raw_s2    <= raw_s1;
			d_s2      <= d_s1;
			n_s2      <= (dsm_pkg::N_W'(d_s1) << dsm_pkg::DB_DIV_SHIFT)
				+ dsm_pkg::N_W'(signed'(spr_s1));
			dv_s2     <= {spr_s1[dsm_pkg::SPR_W-2:0], 1'b0};
			use_s2    <= !spr_s1[dsm_pkg::SPR_W-1] && (spr_s1 >= dsm_pkg::SPREAD_MIN);
			raw_s[0]  <= raw_s2;
			d_s[0]    <= d_s2;
			use_s[0]  <= use_s2;
			neg_s[0]  <= n_s2[dsm_pkg::N_W-1];
			dv_s[0]   <= dv_s2;
			rem_s[0]  <= '0;
			nq_s[0]   <= numer_c[QW-1:0];
		end
	end

	for (genvar gk = 0; gk < QW; gk++) begin : g_div
		logic [dsm_pkg::REM_W-1:0] shl;
		logic                      ge;

		assign shl = {rem_s[gk][dsm_pkg::REM_W-2:0], nq_s[gk][QW-1]};
		assign ge  = (shl >= dsm_pkg::REM_W'(dv_s[gk]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				f_s[gk+1] <= '0;
			end else if (en) begin
				f_s[gk+1] <= f_s[gk];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				raw_s[gk+1] <= raw_s[gk];
				d_s[gk+1]   <= d_s[gk];
				use_s[gk+1] <= use_s[gk];
				neg_s[gk+1] <= neg_s[gk];
				dv_s[gk+1]  <= dv_s[gk];
				rem_s[gk+1] <= ge ? (shl - dsm_pkg::REM_W'(dv_s[gk])) : shl;
				nq_s[gk+1]  <= {nq_s[gk][QW-2:0], ge};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_s4 <= '0;
		end else if (en) begin
			f_s4 <= f_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s4 <= raw_s[QW];
			if (!use_s[QW]) begin
				delta_s4 <= dsm_pkg::DELTA_W'(d_s[QW]);
			end else if (neg_s[QW]) begin
				delta_s4 <= -dsm_pkg::DELTA_W'(nq_s[QW]);
			end else begin
				delta_s4 <= dsm_pkg::DELTA_W'(nq_s[QW]);
			end
		end
	end

	assign flags = f_s4;
	assign raw   = raw_s4;
	assign delta = delta_s4;

endmodule

// ----- sv/dsm_exp.sv -----
module dsm_exp #(
	parameter int SB = dsm_pkg::SAMPLE_BITS_DEF,
	parameter int L  = dsm_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  dsm_pkg::flags_t                     flags_in,
	input  logic [SB-1:0]                       raw_in,
	input  logic signed [dsm_pkg::DELTA_W-1:0]  delta,
	input  logic signed [dsm_pkg::TGT_W-1:0]    target_db,
	input  logic                                pass,
	output logic                                valid,
	output logic [SB-1:0]                       sample,
	output logic                                clip
);

	localparam logic [SB-1:0] FS     = SB'(1) << (SB - 1);
	localparam logic [SB-1:0] FS_MAX = FS - SB'(1);
	localparam int            PW     = dsm_pkg::P_W;

	dsm_pkg::flags_t                     f_s1, f_s2, f_s4, f_s5;
	logic [SB-1:0]                       raw_s1, raw_s2, raw_s4, raw_s5;
	logic signed [dsm_pkg::NEWDB_W-1:0]  ndb_s1;
	logic                                ge0_s2, ge0_s4, ge0_s5;
	logic [dsm_pkg::B_W-1:0]             b_s2;
	logic [63:0]                         tmp_s4;
	logic [dsm_pkg::IP_W-1:0]            sh_s4;
	logic                                big_s4;
	logic [SB-1:0]                       mag_s5;
	logic                                v_s6;
	logic [SB-1:0]                       sample_s6;
	logic                                clip_s6;

	dsm_pkg::flags_t                     f_s   [L+1];
	logic [SB-1:0]                       raw_s [L+1];
	logic                                ge0_s [L+1];
	logic [dsm_pkg::IP_W-1:0]            ip_s  [L+1];
	logic [L-1:0]                        j_s   [L+1];
	logic [PW-1:0]                       p_s   [L+1];

	logic [dsm_pkg::NEWDB_W-1:0]         bfull_c;
	logic [38:0]                         a_prod_c;
	logic [dsm_pkg::A_W-1:0]             a_c;
	logic [dsm_pkg::IP_W-1:0]            sh_c;
	logic [63:0]                         shr_c;
	logic [SB-1:0]                       mag_c, sat_c;
	logic                                clip_c;

	assign bfull_c  = -ndb_s1;
	assign a_prod_c = 39'(b_s2) * 39'(dsm_pkg::LOG2_PER_DB_Q24) + 39'd32768;
	assign a_c      = a_prod_c[38:16];
	assign sh_c     = 7'd30 + ip_s[L];
	assign shr_c    = tmp_s4 >> sh_s4;
	assign mag_c    = ge0_s5 ? FS : mag_s5;
	assign clip_c   = mag_c[SB-1];
	assign sat_c    = clip_c ? FS_MAX : mag_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_s1   <= '0;
			f_s2   <= '0;
			f_s[0] <= '0;
		end else if (en) begin
			f_s1   <= flags_in;
			f_s2   <= f_s1;
			f_s[0] <= f_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s1   <= raw_in;
			ndb_s1   <= dsm_pkg::NEWDB_W'(target_db) - dsm_pkg::NEWDB_W'(delta);
			raw_s2   <= raw_s1;
			ge0_s2   <= !ndb_s1[dsm_pkg::NEWDB_W-1];
			b_s2     <= (|bfull_c[dsm_pkg::NEWDB_W-1:dsm_pkg::B_W]) ? '1
				: bfull_c[dsm_pkg::B_W-1:0];
			raw_s[0] <= raw_s2;
			ge0_s[0] <= ge0_s2;
			ip_s[0]  <= a_c[dsm_pkg::A_W-1:16];
			j_s[0]   <= a_c[15 -: L];
			p_s[0]   <= PW'(1) << 30;
		end
	end

	for (genvar gk = 0; gk < L; gk++) begin : g_exp
		localparam logic [PW-1:0] STEP_C = dsm_pkg::EXP_STEP_Q30[L-gk];
		logic [2*PW-1:0] prod;

		assign prod = (2*PW)'(p_s[gk]) * (2*PW)'(STEP_C) + ((2*PW)'(1) << 29);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				f_s[gk+1] <= '0;
			end else if (en) begin
				f_s[gk+1] <= f_s[gk];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				raw_s[gk+1] <= raw_s[gk];
				ge0_s[gk+1] <= ge0_s[gk];
				ip_s[gk+1]  <= ip_s[gk];
				j_s[gk+1]   <= j_s[gk];
				p_s[gk+1]   <= j_s[gk][gk] ? prod[60:30] : p_s[gk];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_s4 <= '0;
			f_s5 <= '0;
			v_s6 <= 1'b0;
		end else if (en) begin
			f_s4 <= f_s[L];
			f_s5 <= f_s4;
			v_s6 <= f_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s4 <= raw_s[L];
			ge0_s4 <= ge0_s[L];
			big_s4 <= (ip_s[L] > dsm_pkg::EXP_MAX_SHIFT);
			sh_s4  <= sh_c;
			tmp_s4 <= (64'(p_s[L]) << (SB - 1)) + (64'd1 << (sh_c - 7'd1));
			raw_s5 <= raw_s4;
			ge0_s5 <= ge0_s4;
			mag_s5 <= big_s4 ? '0 : shr_c[SB-1:0];
			if (pass) begin
				sample_s6 <= raw_s5;
				clip_s6   <= 1'b0;
			end else if (f_s5.zero) begin
				sample_s6 <= '0;
				clip_s6   <= 1'b0;
			end else begin
				sample_s6 <= raw_s5[SB-1] ? SB'(-sat_c) : sat_c;
				clip_s6   <= clip_c;
			end
		end
	end

	assign valid  = v_s6;
	assign sample = sample_s6;
	assign clip   = clip_s6;

endmodule
